[design/cie_pkg.sv]
// shared types, codes and constants of the counter instruction engine
// no dependencies
`default_nettype none

package cie_pkg;

  localparam int SLOTS_DEFAULT = 256;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = 2;
  localparam int QCNT_W        = 3;

  localparam int WORD_W  = 16;
  localparam int VALUE_W = 64;
  localparam int CFG_W   = 9;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 9'd256;

  localparam logic [3:0] KIND_MASK = 4'hF;

  localparam logic [3:0] OP_SET = 4'd1;
  localparam logic [3:0] OP_INC = 4'd3;
  localparam logic [3:0] OP_DEC = 4'd4;
  localparam logic [3:0] OP_ADD = 4'd5;
  localparam logic [3:0] OP_SUB = 4'd6;

  localparam logic [3:0] CMP_EQ = 4'd1;
  localparam logic [3:0] CMP_NE = 4'd2;
  localparam logic [3:0] CMP_LT = 4'd3;
  localparam logic [3:0] CMP_GT = 4'd4;
  localparam logic [3:0] CMP_LE = 4'd5;
  localparam logic [3:0] CMP_GE = 4'd6;

  localparam logic [3:0] KIND_ZERO = 4'd0;
  localparam logic [3:0] KIND_SLOT = 4'd1;
  localparam logic [3:0] KIND_S16  = 4'd2;
  localparam logic [3:0] KIND_U16  = 4'd3;
  localparam logic [3:0] KIND_S32  = 4'd4;
  localparam logic [3:0] KIND_U32  = 4'd5;
  localparam logic [3:0] KIND_S64  = 4'd6;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_BAD_KIND   = 3'd2;
  localparam logic [2:0] ST_NO_TARGET  = 3'd3;
  localparam logic [2:0] ST_RANGE      = 3'd4;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_TARGET,
    PH_OPERAND
  } phase_e;

  // one queued request from the decoder to the executor
  typedef struct packed {
    logic               exec;
    logic [3:0]         op;
    logic [3:0]         cmp;
    logic [WORD_W-1:0]  tgt;
    logic               use_slot;
    logic [WORD_W-1:0]  bslot;
    logic [VALUE_W-1:0] imm;
    logic [2:0]         status;
    logic               last;
  } cmd_t;

  function automatic logic [2:0] kind_words(input logic [3:0] kind);
    logic [2:0] n;
    unique case (kind)
      KIND_SLOT, KIND_S16, KIND_U16: n = 3'd1;
      KIND_S32, KIND_U32:            n = 3'd2;
      KIND_S64:                      n = 3'd4;
      default:                       n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[design/counter_instruction_engine_core.sv]
// top level of the counter instruction engine: decoder, queue, executor
// depends on cie_pkg, cie_front, cie_queue, cie_back, cie_ram
`default_nettype none

// Runs a stream of 16-bit code words against SLOTS signed 64-bit counters and
// gives at most one result per word. One word is accepted per cycle while the
// queue has room; the decoder keeps that pace and hands each finished
// instruction or error through a four-entry request queue to the executor,
// whose counter ram is read when a request leaves the queue and written when
// it commits, with the last write forwarded, so the executor also sustains one
// request per cycle while the result side keeps up. A result passes the queue,
// the executor stage and the result register, and waits while the output is held.
// After reset the counter store is cleared one slot a cycle, and no word is
// taken until all are cleared; configuration writes are taken at any time.

module counter_instruction_engine_core
  import cie_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // code_word
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // result_value
  output logic [2:0]       m_axis_tuser,  // status
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [8:0]  cfg_data_i     // slots_in_use
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [CFG_W-1:0] slots_in_use_q;
  logic             accept, push, pop, empty, full, init_done;
  cmd_t             cmd, head;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = init_done && !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= SLOTS_IN_USE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      slots_in_use_q <= cfg_data_i;
    end
  end

  cie_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .word_i         (s_axis_tdata),
    .last_i         (s_axis_tlast),
    .slots_in_use_i (slots_in_use_q),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  cie_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  cie_back #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .init_done_o  (init_done),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

[design/cie_ram.sv]
// generic single-write, dual-read ram with registered read data
// no dependencies
`default_nettype none

module cie_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

[design/cie_front.sv]
// decoder: takes code words, tracks instruction phase, emits requests
// depends on cie_pkg
`default_nettype none

module cie_front
  import cie_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [WORD_W-1:0]  word_i,
  input  wire logic               last_i,
  input  wire logic [CFG_W-1:0]   slots_in_use_i,
  output logic                    push_o,
  output cmd_t                    cmd_o
);

  phase_e             phase_q, phase_d;
  logic               disc_q, disc_d;
  logic [3:0]         op_q, op_d;
  logic [3:0]         cmp_q, cmp_d;
  logic [3:0]         kind_q, kind_d;
  logic [WORD_W-1:0]  tgt_q, tgt_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [2:0]         wl_q, wl_d;

  logic               slot_ok;
  logic [VALUE_W-1:0] acc_n;
  logic [2:0]         wl_n;
  logic [VALUE_W-1:0] b_ext;
  logic               err, exec;
  logic [2:0]         st;

  assign slot_ok = ({1'b0, word_i} < 17'(SLOTS)) &&
                   (word_i < {{(WORD_W-CFG_W){1'b0}}, slots_in_use_i});
  assign acc_n = {acc_q[VALUE_W-WORD_W-1:0], word_i};
  assign wl_n  = (wl_q != 3'd0) ? wl_q - 3'd1 : 3'd0;

  always_comb begin
    unique case (kind_q)
      KIND_S16: b_ext = {{48{acc_n[15]}}, acc_n[15:0]};
      KIND_S32: b_ext = {{32{acc_n[31]}}, acc_n[31:0]};
      KIND_U32: b_ext = {32'd0, acc_n[31:0]};
      KIND_S64: b_ext = acc_n;
      default:  b_ext = {48'd0, acc_n[15:0]};
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    disc_d  = disc_q;
    op_d    = op_q;
    cmp_d   = cmp_q;
    kind_d  = kind_q;
    tgt_d   = tgt_q;
    acc_d   = acc_q;
    wl_d    = wl_q;
    err     = 1'b0;
    exec    = 1'b0;
    st      = ST_OK;
    if (accept_i) begin
      if (disc_q) begin
        if (last_i) begin
          disc_d  = 1'b0;
          phase_d = PH_HEAD;
        end
      end else begin
        unique case (phase_q)
          PH_HEAD: begin
            op_d   = word_i[15:12];
            cmp_d  = word_i[11:8];
            kind_d = word_i[3:0] & KIND_MASK;
            if (word_i[7:4] != KIND_SLOT) begin
              err = 1'b1;
              st  = ST_NO_TARGET;
            end else begin
              phase_d = PH_TARGET;
            end
          end
          PH_TARGET: begin
            if (!slot_ok) begin
              err = 1'b1;
              st  = ST_RANGE;
            end else if (kind_q > KIND_S64) begin
              err = 1'b1;
              st  = ST_BAD_KIND;
            end else begin
              tgt_d = word_i;
              wl_d  = kind_words(kind_q);
              acc_d = '0;
              if (kind_words(kind_q) == 3'd0) begin
                exec    = 1'b1;
                phase_d = PH_HEAD;
              end else begin
                phase_d = PH_OPERAND;
              end
            end
          end
          default: begin
            acc_d = acc_n;
            wl_d  = wl_n;
            if (kind_q == KIND_SLOT && !slot_ok) begin
              err = 1'b1;
              st  = ST_RANGE;
            end else if (wl_n == 3'd0) begin
              exec    = 1'b1;
              phase_d = PH_HEAD;
            end
          end
        endcase
        if (!err && !exec && last_i && phase_d != PH_HEAD) begin
          err = 1'b1;
          st  = ST_INCOMPLETE;
        end
        if (err) begin
          phase_d = PH_HEAD;
          wl_d    = 3'd0;
          disc_d  = !last_i;
        end
      end
    end
  end

  always_comb begin
    push_o          = err || exec;
    cmd_o.exec      = exec;
    cmd_o.op        = op_q;
    cmd_o.cmp       = cmp_q;
    cmd_o.tgt       = (phase_q == PH_TARGET) ? word_i : tgt_q;
    cmd_o.use_slot  = (phase_q == PH_OPERAND) && (kind_q == KIND_SLOT);
    cmd_o.bslot     = word_i;
    cmd_o.imm       = (phase_q == PH_OPERAND) ? b_ext : '0;
    cmd_o.status    = st;
    cmd_o.last      = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      disc_q  <= 1'b0;
      op_q    <= '0;
      cmp_q   <= '0;
      kind_q  <= '0;
      tgt_q   <= '0;
      acc_q   <= '0;
      wl_q    <= '0;
    end else begin
      phase_q <= phase_d;
      disc_q  <= disc_d;
      op_q    <= op_d;
      cmp_q   <= cmp_d;
      kind_q  <= kind_d;
      tgt_q   <= tgt_d;
      acc_q   <= acc_d;
      wl_q    <= wl_d;
    end
  end

endmodule

`default_nettype wire

[design/cie_queue.sv]
// short request queue between decoder and executor
// depends on cie_pkg
`default_nettype none

module cie_queue
  import cie_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  cmd_t              buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = buf_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[design/cie_back.sv]
// executor: counter store, compare and update, result register
// depends on cie_pkg and cie_ram
`default_nettype none

module cie_back
  import cie_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEFAULT,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               head_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  output logic                    init_done_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [VALUE_W-1:0]      out_value_o,
  output logic [2:0]              out_status_o,
  output logic                    out_last_o
);

  logic               init_done_q;
  logic [SLOT_W-1:0]  clr_q;

  logic               b_valid_q;
  cmd_t               b_cmd_q;

  logic               lw_valid_q;
  logic [SLOT_W-1:0]  lw_addr_q;
  logic [VALUE_W-1:0] lw_data_q;

  logic               o_valid_q;
  logic [VALUE_W-1:0] o_value_q;
  logic [2:0]         o_status_q;
  logic               o_last_q;

  logic               out_take, adv, commit, wr_exec, we;
  logic [SLOT_W-1:0]  waddr, t_addr, s_addr;
  logic [VALUE_W-1:0] wdata, rd_a, rd_b;
  logic [VALUE_W-1:0] a, b, bs, res;
  logic               eq, lt, gt, fail;

  assign out_take = !o_valid_q || out_ready_i;
  assign adv      = !b_valid_q || out_take;
  assign pop_o    = init_done_q && !empty_i && adv;
  assign commit   = b_valid_q && out_take;
  assign wr_exec  = commit && b_cmd_q.exec;

  assign t_addr = b_cmd_q.tgt[SLOT_W-1:0];
  assign s_addr = b_cmd_q.bslot[SLOT_W-1:0];

  assign we    = !init_done_q || wr_exec;
  assign waddr = init_done_q ? t_addr : clr_q;
  assign wdata = init_done_q ? res : '0;

  cie_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (SLOTS),
    .AW    (SLOT_W)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (pop_o),
    .raddr_a_i (head_i.tgt[SLOT_W-1:0]),
    .raddr_b_i (head_i.bslot[SLOT_W-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // forward the last write, which the ram read missed
  always_comb begin
    a   = (lw_valid_q && lw_addr_q == t_addr) ? lw_data_q : rd_a;
    bs  = (lw_valid_q && lw_addr_q == s_addr) ? lw_data_q : rd_b;
    b   = b_cmd_q.use_slot ? bs : b_cmd_q.imm;
    eq  = (a == b);
    lt  = ($signed(a) < $signed(b));
    gt  = ($signed(b) < $signed(a));
    unique case (b_cmd_q.cmp)
      CMP_EQ:  fail = !eq;
      CMP_NE:  fail = eq;
      CMP_LT:  fail = !lt;
      CMP_GT:  fail = !gt;
      CMP_LE:  fail = gt;
      CMP_GE:  fail = lt;
      default: fail = 1'b0;
    endcase
    if (fail) begin
      res = a;
    end else begin
      unique case (b_cmd_q.op)
        OP_SET:  res = b;
        OP_INC:  res = a + 64'd1;
        OP_DEC:  res = a - 64'd1;
        OP_ADD:  res = a + b;
        OP_SUB:  res = a - b;
        default: res = a;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_done_q <= 1'b0;
      clr_q       <= '0;
      b_valid_q   <= 1'b0;
      lw_valid_q  <= 1'b0;
      o_valid_q   <= 1'b0;
    end else begin
      if (!init_done_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == SLOT_W'(SLOTS - 1)) begin
          init_done_q <= 1'b1;
        end
      end
      if (adv) begin
        b_valid_q <= pop_o;
      end
      if (wr_exec) begin
        lw_valid_q <= 1'b1;
      end
      if (commit) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_cmd_q <= head_i;
    end
    if (wr_exec) begin
      lw_addr_q <= t_addr;
      lw_data_q <= res;
    end
    if (commit) begin
      o_value_q  <= b_cmd_q.exec ? res : '0;
      o_status_q <= b_cmd_q.exec ? ST_OK : b_cmd_q.status;
      o_last_q   <= b_cmd_q.last;
    end
  end

  assign init_done_o  = init_done_q;
  assign out_valid_o  = o_valid_q;
  assign out_value_o  = o_value_q;
  assign out_status_o = o_status_q;
  assign out_last_o   = o_last_q;

endmodule

`default_nettype wire
